### rtl/mse_pkg.sv
// Shared types, opcodes and helpers for the MIPS subset execute unit.
package mse_pkg;

  localparam logic [31:0] PC_RESET    = 32'h0040_0000;
  localparam logic [31:0] PC_SEG_MASK = 32'hf000_0000;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
  localparam logic [31:0] SYS_EXIT       = 32'd10;
  localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;

  localparam logic CON_INT  = 1'b0;
  localparam logic CON_CHAR = 1'b1;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef enum logic [4:0] {
    K_NOP, K_PRELOAD, K_JR, K_ADD, K_ADDU, K_SUB, K_SLT, K_SLL, K_SRL,
    K_AND, K_OR, K_XOR, K_SYSCALL, K_ADDI, K_ANDI, K_ORI, K_XORI, K_SLTI,
    K_LUI, K_LW, K_LH, K_LB, K_SW, K_SH, K_SB, K_BEQ, K_BNE, K_J, K_JAL
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dst;
    logic [4:0]  shamt;
    logic [15:0] imm;
    logic [25:0] target;
    logic [31:0] pre_addr;
    logic [31:0] pre_data;
  } item_t;

  function automatic logic is_mem(kind_t k);
    return k == K_PRELOAD || k == K_LW || k == K_LH || k == K_LB ||
           k == K_SW || k == K_SH || k == K_SB;
  endfunction

  // memory ops that finish without reading the word first
  function automatic logic is_write_only(kind_t k);
    return k == K_PRELOAD || k == K_SW;
  endfunction

endpackage

### rtl/mse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mse_front.sv
// Front end: accepts beats, decodes them and queues them for the back end.
module mse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          command,
  input  logic [31:0]   instruction_word,
  input  logic [31:0]   preload_address,
  input  logic [31:0]   preload_data,
  input  logic          clearing,
  output logic          q_valid,
  output mse_pkg::item_t q_item,
  input  logic          q_pop
);
  import mse_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW = $clog2(QDEPTH);

  item_t         fifo [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;
  item_t         dec;
  logic          push;

  always_comb begin
    logic [5:0] op;
    logic [5:0] fn;
    op = instruction_word[31:26];
    fn = instruction_word[5:0];
    dec.rs       = instruction_word[25:21];
    dec.rt       = instruction_word[20:16];
    dec.dst      = instruction_word[20:16];
    dec.shamt    = instruction_word[10:6];
    dec.imm      = instruction_word[15:0];
    dec.target   = instruction_word[25:0];
    dec.pre_addr = preload_address;
    dec.pre_data = preload_data;
    dec.kind     = K_NOP;
    if (command) begin
      dec.kind = K_PRELOAD;
    end else if (op == OP_SPECIAL) begin
      dec.dst = instruction_word[15:11];
      unique case (fn)
        FN_SLL:     dec.kind = K_SLL;
        FN_SRL:     dec.kind = K_SRL;
        FN_JR:      dec.kind = K_JR;
        FN_SYSCALL: dec.kind = K_SYSCALL;
        FN_ADD:     dec.kind = K_ADD;
        FN_ADDU:    dec.kind = K_ADDU;
        FN_SUB:     dec.kind = K_SUB;
        FN_AND:     dec.kind = K_AND;
        FN_OR:      dec.kind = K_OR;
        FN_XOR:     dec.kind = K_XOR;
        FN_SLT:     dec.kind = K_SLT;
        default:    dec.kind = K_NOP;
      endcase
    end else begin
      unique case (op)
        OP_J:     dec.kind = K_J;
        OP_JAL:   begin dec.kind = K_JAL; dec.dst = LINK_REG; end
        OP_BEQ:   dec.kind = K_BEQ;
        OP_BNE:   dec.kind = K_BNE;
        OP_ADDI:  dec.kind = K_ADDI;
        OP_ADDIU: dec.kind = K_ADDI;
        OP_SLTI:  dec.kind = K_SLTI;
        OP_ANDI:  dec.kind = K_ANDI;
        OP_ORI:   dec.kind = K_ORI;
        OP_XORI:  dec.kind = K_XORI;
        OP_LUI:   dec.kind = K_LUI;
        OP_LB:    dec.kind = K_LB;
        OP_LH:    dec.kind = K_LH;
        OP_LW:    dec.kind = K_LW;
        OP_SB:    dec.kind = K_SB;
        OP_SH:    dec.kind = K_SH;
        OP_SW:    dec.kind = K_SW;
        default:  dec.kind = K_NOP;
      endcase
    end
  end

  assign in_ready = !clearing && (count != (PW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = count != '0;
  assign q_item   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= dec;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/mse_back.sv
// Back end: register file, data memory, execution sequencer and result register.
module mse_back #(
  parameter int DATA_WORDS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mse_pkg::item_t q_item,
  output logic          q_pop,
  output logic          clearing,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   next_pc,
  output logic          halted,
  output logic          overflow,
  output logic          reg_written,
  output logic [4:0]    reg_index,
  output logic [31:0]   reg_value,
  output logic          console_valid,
  output logic          console_kind,
  output logic [31:0]   console_value
);
  import mse_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);
  localparam bit POW2 = (DATA_WORDS == (1 << AW));
  localparam int MOD_SHIFT = 30 + AW;
  localparam logic [63:0] MOD_MUL = (64'd1 << MOD_SHIFT) / 64'(DATA_WORDS) + 64'd1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_MOD1, S_MOD2, S_MEM, S_WB
  } state_t;

  state_t        state;
  item_t         cur;
  logic [31:0]   pc;
  logic          stopped;
  logic [31:0]   r2;
  logic [31:0]   r4;
  logic [31:0]   regvalid;
  logic [AW-1:0] clr_idx;
  logic [31:0]   maddr;
  logic [AW-1:0] midx;
  logic [61:0]   prod1;
  logic [30:0]   qd;

  logic [31:0]   rda;
  logic [31:0]   rdb;
  logic [31:0]   mrd;
  logic [31:0]   a;
  logic [31:0]   b;
  logic [31:0]   simm;
  logic [31:0]   pc4;
  logic [31:0]   addr;
  logic          go_mem;
  logic          out_free;
  logic [30:0]   mdiff;
  logic [30:0]   mod_idx;
  logic [AW-1:0] mem_idx;
  logic [61:0]   qsh;
  logic [47:0]   qd_full;

  logic          fin;
  logic [31:0]   npc;
  logic          wr;
  logic [31:0]   wval;
  logic          ovf;
  logic          halt;
  logic          con;
  logic          ckind;
  logic [31:0]   cval;
  logic          reg_we;
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;
  logic          dm_re;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign clearing = (state == S_CLEAR);
  assign out_free = !out_valid || out_ready;

  assign a    = regvalid[cur.rs] ? rda : 32'd0;
  assign b    = regvalid[cur.rt] ? rdb : 32'd0;
  assign simm = {{16{cur.imm[15]}}, cur.imm};
  assign pc4  = pc + 32'd4;
  assign addr = (cur.kind == K_PRELOAD) ? cur.pre_addr : a + simm;
  assign go_mem = is_mem(cur.kind) && (cur.kind == K_PRELOAD || !stopped);

  // word index modulo DATA_WORDS; quotient estimate is exact or one high
  assign qsh     = prod1 >> MOD_SHIFT;
  assign qd_full = {18'd0, qsh[29:0]} * 48'(DATA_WORDS);
  assign mdiff   = {1'b0, maddr[31:2]} - qd;
  assign mod_idx = mdiff[30] ? mdiff + 31'(DATA_WORDS) : mdiff;
  assign mem_idx = POW2 ? maddr[2 +: AW] : mod_idx[AW-1:0];

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rfa (
    .clk(clk), .we(reg_we), .waddr(cur.dst), .wdata(wval),
    .re(q_pop), .raddr(q_item.rs), .rdata(rda)
  );

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rfb (
    .clk(clk), .we(reg_we), .waddr(cur.dst), .wdata(wval),
    .re(q_pop), .raddr(q_item.rt), .rdata(rdb)
  );

  mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(dm_re), .raddr(mem_idx), .rdata(mrd)
  );

  always_comb begin
    logic [15:0] half;
    logic [7:0]  byt;
    half = maddr[1] ? mrd[31:16] : mrd[15:0];
    unique case (maddr[1:0])
      2'd0:    byt = mrd[7:0];
      2'd1:    byt = mrd[15:8];
      2'd2:    byt = mrd[23:16];
      default: byt = mrd[31:24];
    endcase

    fin      = 1'b0;
    npc      = pc4;
    wr       = 1'b0;
    wval     = 32'd0;
    ovf      = 1'b0;
    halt     = 1'b0;
    con      = 1'b0;
    ckind    = CON_INT;
    cval     = 32'd0;
    dm_we    = 1'b0;
    dm_waddr = midx;
    dm_wdata = b;
    dm_re    = 1'b0;

    unique case (state)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_idx;
        dm_wdata = 32'd0;
      end
      S_EXEC: begin
        if (!go_mem) begin
          fin = out_free;
          unique case (cur.kind)
            K_JR:   npc = a;
            K_ADD: begin
              wr   = 1'b1;
              wval = a + b;
              ovf  = ((a ^ wval) & (b ^ wval)) >> 31 != 32'd0;
              halt = ovf;
            end
            K_ADDU: begin wr = 1'b1; wval = a + b; end
            K_SUB:  begin wr = 1'b1; wval = a - b; end
            K_SLT:  begin wr = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
            K_SLL:  begin wr = 1'b1; wval = b << cur.shamt; end
            K_SRL:  begin wr = 1'b1; wval = b >> cur.shamt; end
            K_AND:  begin wr = 1'b1; wval = a & b; end
            K_OR:   begin wr = 1'b1; wval = a | b; end
            K_XOR:  begin wr = 1'b1; wval = a ^ b; end
            K_ADDI: begin wr = 1'b1; wval = a + simm; end
            K_ANDI: begin wr = 1'b1; wval = a & {16'd0, cur.imm}; end
            K_ORI:  begin wr = 1'b1; wval = a | {16'd0, cur.imm}; end
            K_XORI: begin wr = 1'b1; wval = a ^ {16'd0, cur.imm}; end
            K_SLTI: begin wr = 1'b1; wval = {31'd0, $signed(a) < $signed(simm)}; end
            K_LUI:  begin wr = 1'b1; wval = {cur.imm, 16'd0}; end
            K_BEQ:  if (a == b) npc = pc4 + {simm[29:0], 2'b00};
            K_BNE:  if (a != b) npc = pc4 + {simm[29:0], 2'b00};
            K_J:    npc = (pc4 & PC_SEG_MASK) | {4'd0, cur.target, 2'b00};
            K_JAL: begin
              wr   = 1'b1;
              wval = pc4;
              npc  = (pc4 & PC_SEG_MASK) | {4'd0, cur.target, 2'b00};
            end
            K_SYSCALL: begin
              if (r2 == SYS_PRINT_INT) begin
                con = 1'b1; ckind = CON_INT; cval = r4;
              end else if (r2 == SYS_PRINT_CHAR) begin
                con = 1'b1; ckind = CON_CHAR; cval = {24'd0, r4[7:0]};
              end else if (r2 == SYS_EXIT) begin
                halt = 1'b1;
              end
            end
            default: ;
          endcase
          if (stopped) begin
            npc = pc; wr = 1'b0; ovf = 1'b0; halt = 1'b0; con = 1'b0;
            ckind = CON_INT; cval = 32'd0;
          end
        end
      end
      S_MEM: begin
        if (is_write_only(cur.kind)) begin
          fin      = out_free;
          dm_we    = fin;
          dm_waddr = mem_idx;
          if (cur.kind == K_PRELOAD) begin
            npc      = pc;
            dm_wdata = cur.pre_data;
          end
        end else begin
          dm_re = 1'b1;
        end
      end
      S_WB: begin
        fin = out_free;
        unique case (cur.kind)
          K_LW: begin wr = 1'b1; wval = mrd; end
          K_LH: begin wr = 1'b1; wval = {{16{half[15]}}, half}; end
          K_LB: begin wr = 1'b1; wval = {{24{byt[7]}}, byt}; end
          K_SH: begin
            dm_we    = fin;
            dm_wdata = maddr[1] ? {b[15:0], mrd[15:0]} : {mrd[31:16], b[15:0]};
          end
          K_SB: begin
            dm_we = fin;
            unique case (maddr[1:0])
              2'd0:    dm_wdata = {mrd[31:8], b[7:0]};
              2'd1:    dm_wdata = {mrd[31:16], b[7:0], mrd[7:0]};
              2'd2:    dm_wdata = {mrd[31:24], b[7:0], mrd[15:0]};
              default: dm_wdata = {b[7:0], mrd[23:0]};
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // r0 never takes a write
    if (cur.dst == 5'd0) begin
      wr = 1'b0;
    end
    if (!wr) begin
      wval = 32'd0;
    end
  end

  assign reg_we = fin && wr;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == S_EXEC) begin
      maddr <= addr;
    end
    if (state == S_MOD1) begin
      prod1 <= {32'd0, maddr[31:2]} * {30'd0, MOD_MUL[31:0]};
    end
    if (state == S_MOD2) begin
      qd <= qd_full[30:0];
    end
    if (state == S_MEM) begin
      midx <= mem_idx;
    end
    if (fin) begin
      next_pc       <= npc;
      halted        <= stopped | halt;
      overflow      <= ovf;
      reg_written   <= wr;
      reg_index     <= wr ? cur.dst : 5'd0;
      reg_value     <= wval;
      console_valid <= con;
      console_kind  <= ckind;
      console_value <= cval;
    end
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      pc        <= PC_RESET;
      stopped   <= 1'b0;
      r2        <= 32'd0;
      r4        <= 32'd0;
      regvalid  <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (fin) begin
        out_valid <= 1'b1;
        pc        <= npc;
        stopped   <= stopped | halt;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (reg_we) begin
        regvalid[cur.dst] <= 1'b1;
        if (cur.dst == 5'd2) r2 <= wval;
        if (cur.dst == 5'd4) r4 <= wval;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(DATA_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (go_mem) begin
            state <= POW2 ? S_MEM : S_MOD1;
          end else if (fin) begin
            state <= S_IDLE;
          end
        end
        S_MOD1: state <= S_MOD2;
        S_MOD2: state <= S_MEM;
        S_MEM: begin
          if (!is_write_only(cur.kind)) begin
            state <= S_WB;
          end else if (fin) begin
            state <= S_IDLE;
          end
        end
        S_WB: begin
          if (fin) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/mips_subset_execute_unit_top.sv
// Top level of the MIPS subset execute unit: front end, queue and back end.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | command, instruction_word, preload_*
//  out     | output    | out_valid/out_ready | next_pc, halted, overflow, reg_*, console_*
//
// ALU, branch, jump and syscall beats take a register file read, then execute and
// write; loads, sh and sb add a memory read and a write-back, sw and preload a
// memory write, with the modulo index multiply states S_MOD1 and S_MOD2 first
// when DATA_WORDS is not a power of 2. After reset the data memory is zeroed one
// word per cycle with in_ready low until every word is cleared. A two-entry queue
// keeps the front accepting while the back end or the result register stalls.
module mips_subset_execute_unit_top #(
  parameter int DATA_WORDS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [31:0]        instruction_word,
  input  logic [31:0]        preload_address,
  input  logic [31:0]        preload_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        next_pc,
  output logic               halted,
  output logic               overflow,
  output logic               reg_written,
  output logic [4:0]         reg_index,
  output logic signed [31:0] reg_value,
  output logic               console_valid,
  output logic               console_kind,
  output logic signed [31:0] console_value
);
  import mse_pkg::*;

  item_t       q_item;
  logic        q_valid;
  logic        q_pop;
  logic        clearing;
  logic [31:0] reg_value_u;
  logic [31:0] console_value_u;

  mse_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .instruction_word(instruction_word),
    .preload_address(preload_address), .preload_data(preload_data),
    .clearing(clearing),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  mse_back #(.DATA_WORDS(DATA_WORDS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .clearing(clearing),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pc(next_pc), .halted(halted), .overflow(overflow),
    .reg_written(reg_written), .reg_index(reg_index), .reg_value(reg_value_u),
    .console_valid(console_valid), .console_kind(console_kind),
    .console_value(console_value_u)
  );

  assign reg_value     = $signed(reg_value_u);
  assign console_value = $signed(console_value_u);

endmodule

### tb/mips_subset_execute_unit_top_test.sv
// Self-checking testbench for the MIPS subset execute unit: a shadow machine predicts every beat.
`timescale 1ns / 1ps

module mips_subset_execute_unit_top_test;
  import mse_pkg::*;

  localparam int DATA_WORDS = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;
  localparam logic [31:0] NOP_WORD = 32'h0;

  typedef struct {
    logic [31:0] next_pc;
    logic        halted;
    logic        overflow;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        console_valid;
    logic        console_kind;
    logic [31:0] console_value;
  } exec_result_t;

  class mips_shadow;
    logic [31:0] gpr [32];
    logic [31:0] pc;
    logic [31:0] dmem [DATA_WORDS];
    logic stopped;
    exec_result_t pending_results [$];
    int errors;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = PC_RESET;
      stopped = 1'b0;
      errors = 0;
    endfunction

    function exec_result_t run_beat(logic cmd, logic [31:0] ins, logic [31:0] pa,
                                    logic [31:0] pd);
      exec_result_t r;
      logic [5:0] op, fn;
      logic [4:0] rs, rt, rd, sa, widx;
      logic [31:0] simm, zimm, a, b, addr, w, wval;
      int wi, bsh, hsh;
      logic wr;
      r = '{default: '0};
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
      sa = ins[10:6]; fn = ins[5:0];
      simm = {{16{ins[15]}}, ins[15:0]};
      zimm = {16'b0, ins[15:0]};
      a = gpr[rs]; b = gpr[rt];
      addr = a + simm;
      wi = (addr >> 2) % DATA_WORDS;
      bsh = addr[1:0] * 8;
      hsh = addr[1] * 16;
      wr = 1'b0; widx = '0; wval = '0;
      if (cmd == CMD_PRELOAD) begin
        dmem[(pa >> 2) % DATA_WORDS] = pd;
      end else if (!stopped) begin
        pc = pc + 4;
        if (op == OP_SPECIAL) begin
          widx = rd; wr = 1'b1;
          case (fn)
            FN_JR: begin pc = a; wr = 1'b0; end
            FN_ADD: begin
              wval = a + b;
              r.overflow = (a[31] == b[31]) && (wval[31] != a[31]);
              if (r.overflow) stopped = 1'b1;
            end
            FN_ADDU: wval = a + b;
            FN_SUB:  wval = a - b;
            FN_SLT:  wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            FN_SLL:  wval = b << sa;
            FN_SRL:  wval = b >> sa;
            FN_AND:  wval = a & b;
            FN_OR:   wval = a | b;
            FN_XOR:  wval = a ^ b;
            FN_SYSCALL: begin
              wr = 1'b0;
              if (gpr[2] == SYS_PRINT_INT) begin
                r.console_valid = 1'b1; r.console_kind = CON_INT; r.console_value = gpr[4];
              end else if (gpr[2] == SYS_PRINT_CHAR) begin
                r.console_valid = 1'b1; r.console_kind = CON_CHAR;
                r.console_value = {24'b0, gpr[4][7:0]};
              end else if (gpr[2] == SYS_EXIT) begin
                stopped = 1'b1;
              end
            end
            default: wr = 1'b0;
          endcase
        end else if (op == OP_J || op == OP_JAL) begin
          if (op == OP_JAL) begin
            wr = 1'b1; widx = LINK_REG; wval = pc;
          end
          pc = (pc & PC_SEG_MASK) | {4'b0, ins[25:0], 2'b00};
        end else begin
          widx = rt; wr = 1'b1;
          case (op)
            OP_ADDI, OP_ADDIU: wval = a + simm;
            OP_ANDI: wval = a & zimm;
            OP_ORI:  wval = a | zimm;
            OP_XORI: wval = a ^ zimm;
            OP_SLTI: wval = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
            OP_LUI:  wval = {ins[15:0], 16'b0};
            OP_LW:   wval = dmem[wi];
            OP_LH: begin
              w = dmem[wi] >> hsh;
              wval = {{16{w[15]}}, w[15:0]};
            end
            OP_LB: begin
              w = dmem[wi] >> bsh;
              wval = {{24{w[7]}}, w[7:0]};
            end
            OP_SW: begin dmem[wi] = b; wr = 1'b0; end
            OP_SH: begin
              dmem[wi] = (dmem[wi] & ~(32'h0000ffff << hsh)) | ({16'b0, b[15:0]} << hsh);
              wr = 1'b0;
            end
            OP_SB: begin
              dmem[wi] = (dmem[wi] & ~(32'h000000ff << bsh)) | ({24'b0, b[7:0]} << bsh);
              wr = 1'b0;
            end
            OP_BEQ: begin
              if (a == b) pc = pc + (simm << 2);
              wr = 1'b0;
            end
            OP_BNE: begin
              if (a != b) pc = pc + (simm << 2);
              wr = 1'b0;
            end
            default: wr = 1'b0;
          endcase
        end
        if (wr && widx != 0) gpr[widx] = wval;
        else begin
          wr = 1'b0; widx = '0; wval = '0;
        end
      end
      r.next_pc = pc;
      r.halted = stopped;
      r.reg_written = wr;
      r.reg_index = widx;
      r.reg_value = wval;
      return r;
    endfunction

    // true when this word would stop the machine (used to keep random runs alive)
    function bit stops_machine(logic [31:0] ins);
      logic [31:0] a, b, s;
      a = gpr[ins[25:21]]; b = gpr[ins[20:16]]; s = a + b;
      if (ins[31:26] != OP_SPECIAL) return 0;
      if (ins[5:0] == FN_ADD) return (a[31] == b[31]) && (s[31] != a[31]);
      if (ins[5:0] == FN_SYSCALL) return gpr[2] == SYS_EXIT;
      return 0;
    endfunction

    function void note_beat(logic cmd, logic [31:0] ins, logic [31:0] pa, logic [31:0] pd);
      pending_results.push_back(run_beat(cmd, ins, pa, pd));
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, got_v);
    endfunction

    function void check_beat(exec_result_t got);
      exec_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, next_pc %h", $time, got.next_pc);
        return;
      end
      e = pending_results.pop_front();
      if (got.next_pc !== e.next_pc) report("next_pc", e.next_pc, got.next_pc);
      if (got.halted !== e.halted) report("halted", e.halted, got.halted);
      if (got.overflow !== e.overflow) report("overflow", e.overflow, got.overflow);
      if (got.reg_written !== e.reg_written)
        report("reg_written", e.reg_written, got.reg_written);
      if (got.reg_index !== e.reg_index) report("reg_index", e.reg_index, got.reg_index);
      if (got.reg_value !== e.reg_value) report("reg_value", e.reg_value, got.reg_value);
      if (got.console_valid !== e.console_valid)
        report("console_valid", e.console_valid, got.console_valid);
      if (got.console_kind !== e.console_kind)
        report("console_kind", e.console_kind, got.console_kind);
      if (got.console_value !== e.console_value)
        report("console_value", e.console_value, got.console_value);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_EXEC;
  logic [31:0] instruction_word = '0;
  logic [31:0] preload_address = '0;
  logic [31:0] preload_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] next_pc;
  logic halted, overflow, reg_written;
  logic [4:0] reg_index;
  logic signed [31:0] reg_value;
  logic console_valid, console_kind;
  logic signed [31:0] console_value;

  mips_shadow shadow = new();
  int cycles = 0;
  bit quiet_out = 0;

  mips_subset_execute_unit_top #(.DATA_WORDS(DATA_WORDS)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      shadow.check_beat('{next_pc, halted, overflow, reg_written, reg_index, reg_value,
                          console_valid, console_kind, console_value});
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result-side back pressure, with some stall-free stretches
  initial begin
    @(negedge rst);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet_out && $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sa, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  bit keep_running = 1;

  task automatic send_beat(logic cmd, logic [31:0] ins, logic [31:0] pa, logic [31:0] pd);
    int gap;
    if (cmd == CMD_EXEC && keep_running && shadow.stops_machine(ins)) ins = NOP_WORD;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    instruction_word <= ins;
    preload_address <= pa;
    preload_data <= pd;
    do @(posedge clk); while (!in_ready);
    shadow.note_beat(cmd, ins, pa, pd);
  endtask

  task automatic exec_word(logic [31:0] ins);
    send_beat(CMD_EXEC, ins, $urandom, $urandom);
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  task automatic random_beat();
    logic [5:0] rfns [10] = '{FN_ADD, FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_SLT,
                              FN_SLL, FN_SRL, FN_JR};
    logic [5:0] iops [9] = '{OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI, OP_LUI,
                             OP_BEQ, OP_BNE};
    logic [5:0] mops [6] = '{OP_LW, OP_LH, OP_LB, OP_SW, OP_SH, OP_SB};
    logic [31:0] sys_codes [4] = '{SYS_PRINT_INT, SYS_PRINT_CHAR, 32'd4, 32'd7};
    logic [4:0] base;
    logic [15:0] off;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      send_beat(CMD_PRELOAD, $urandom,
                ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 255)),
                $urandom);
    end else if (roll < 33) begin
      exec_word(rtype(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                      rfns[$urandom_range(0, 9)]));
    end else if (roll < 58) begin
      exec_word(itype(iops[$urandom_range(0, 8)], pick_reg(), pick_reg(), 16'($urandom)));
    end else if (roll < 83) begin
      // mostly small offsets from r0 so stores and loads meet again
      base = ($urandom_range(0, 1) != 0) ? 5'd0 : pick_reg();
      off = (base == 0) ? 16'($urandom_range(0, 127)) : 16'($urandom);
      exec_word(itype(mops[$urandom_range(0, 5)], base, pick_reg(), off));
    end else if (roll < 88) begin
      exec_word({($urandom_range(0, 1) != 0) ? OP_JAL : OP_J, 26'($urandom)});
    end else if (roll < 94) begin
      exec_word(itype(OP_ADDIU, 5'd0, 5'd2, 16'(sys_codes[$urandom_range(0, 3)])));
      exec_word(rtype(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), FN_SYSCALL));
    end else begin
      exec_word($urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every operation, sign and wrap cases
    exec_word(itype(OP_LUI, 5'd0, 5'd8, 16'h7fff));
    exec_word(itype(OP_ORI, 5'd8, 5'd8, 16'hffff));
    exec_word(itype(OP_LUI, 5'd0, 5'd9, 16'h8000));
    exec_word(rtype(5'd8, 5'd9, 5'd10, 5'd0, FN_ADD));
    exec_word(rtype(5'd9, 5'd8, 5'd11, 5'd0, FN_SUB));
    exec_word(rtype(5'd9, 5'd8, 5'd12, 5'd0, FN_SLT));
    exec_word(rtype(5'd0, 5'd9, 5'd13, 5'd31, FN_SRL));
    exec_word(rtype(5'd0, 5'd8, 5'd14, 5'd31, FN_SLL));
    exec_word(rtype(5'd8, 5'd9, 5'd15, 5'd0, FN_AND));
    exec_word(rtype(5'd8, 5'd9, 5'd16, 5'd0, FN_OR));
    exec_word(rtype(5'd8, 5'd8, 5'd17, 5'd0, FN_XOR));
    exec_word(rtype(5'd8, 5'd8, 5'd0, 5'd0, FN_ADDU));
    exec_word(itype(OP_ADDI, 5'd9, 5'd18, 16'hffff));
    exec_word(itype(OP_SLTI, 5'd9, 5'd19, 16'h8000));
    exec_word(itype(OP_XORI, 5'd8, 5'd20, 16'hffff));
    exec_word(itype(OP_ANDI, 5'd9, 5'd21, 16'hffff));
    send_beat(CMD_PRELOAD, '0, 32'hffff_fffc, 32'h80ff_7f01);
    exec_word(itype(OP_LB, 5'd0, 5'd22, 16'h0ffe));
    exec_word(itype(OP_LH, 5'd0, 5'd23, 16'h0ffe));
    exec_word(itype(OP_LW, 5'd0, 5'd24, 16'h0fff));
    exec_word(itype(OP_SB, 5'd0, 5'd9, 16'h0ffd));
    exec_word(itype(OP_SH, 5'd0, 5'd8, 16'h0ffc));
    exec_word(itype(OP_LW, 5'd0, 5'd25, 16'h0ffc));
    exec_word(itype(OP_SW, 5'd0, 5'd8, 16'h0000));
    exec_word(itype(OP_BEQ, 5'd8, 5'd8, 16'h8000));
    exec_word(itype(OP_BNE, 5'd8, 5'd9, 16'h7fff));
    exec_word({OP_JAL, 26'h3ff_ffff});
    exec_word(rtype(5'd31, 5'd0, 5'd0, 5'd0, FN_JR));
    exec_word({OP_J, 26'h010_0000});
    exec_word(itype(OP_ADDIU, 5'd0, 5'd2, 16'd1));
    exec_word(itype(OP_ADDIU, 5'd9, 5'd4, 16'h00c8));
    exec_word(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
    exec_word(itype(OP_ADDIU, 5'd0, 5'd2, 16'd11));
    exec_word(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
    exec_word(itype(OP_ADDIU, 5'd0, 5'd2, 16'd4));
    exec_word(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
    exec_word(32'hffff_ffff);

    for (int n = 0; n < 1100; n++) begin
      if (n == 300 || n == 700) begin
        // drain everything before the next beat
        in_valid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge clk);
      end
      quiet_out = (n >= 500 && n < 600);
      random_beat();
    end

    // finish with one of the two ways to stop, then beats that must change no register or pc
    keep_running = 0;
    if ($urandom_range(0, 1) != 0) begin
      exec_word(itype(OP_LUI, 5'd0, 5'd8, 16'h8000));
      exec_word(rtype(5'd8, 5'd8, 5'd10, 5'd0, FN_ADD));
    end else begin
      exec_word(itype(OP_ADDIU, 5'd0, 5'd2, 16'd10));
      exec_word(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
    end
    exec_word(itype(OP_ADDIU, 5'd0, 5'd3, 16'd5));
    send_beat(CMD_PRELOAD, '0, 32'h0000_0010, 32'h1234_5678);
    exec_word(itype(OP_LW, 5'd0, 5'd3, 16'h0010));
    in_valid <= 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/mse_pkg.sv
rtl/mse_ram.sv
rtl/mse_front.sv
rtl/mse_back.sv
rtl/mips_subset_execute_unit_top.sv
tb/mips_subset_execute_unit_top_test.sv
